FILE: hdl/one_hit_ratio_tracker_assert.svh
// Assertion macros for the one-hit ratio tracker.
`ifndef ONE_HIT_RATIO_TRACKER_ASSERT_SVH
`define ONE_HIT_RATIO_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define OHR_CHECK(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("ohr invariant violated");
`define OHR_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ohr sequence violated");
`else
`define OHR_CHECK(lbl, expr)
`define OHR_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/ohr_pkg.sv
// Shared constants and types for the one-hit ratio tracker.
package ohr_pkg;

    localparam int CAPACITY    = 4096;
    localparam int NUM_CELLS   = 16;
    localparam int LANE_W      = $clog2(NUM_CELLS);
    localparam int ROWS        = CAPACITY / NUM_CELLS;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int ID_W        = 64;
    localparam int LVL_W       = 2;
    localparam int INTERVAL_W  = 16;
    localparam int RATIO_W     = 17;
    localparam int Q_SHIFT     = 16;
    localparam int DVD_W       = CNT_W + Q_SHIFT;
    localparam int DIVISOR_W   = INTERVAL_W;
    localparam int DCNT_W      = $clog2(DVD_W);
    localparam int OUT_W       = 2 * CNT_W + RATIO_W + 1;
    localparam int TDATA_W     = ((OUT_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0]      CAP_CNT        = CNT_W'(CAPACITY);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;
    localparam logic [LVL_W-1:0]      LEVEL_ONCE     = 2'd1;
    localparam logic [LVL_W-1:0]      LEVEL_MAX      = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [ID_W-1:0]  key;
        logic [ROW_W-1:0] row;
        logic             found;
        logic [LANE_W-1:0] hit_lane;
        logic [LVL_W-1:0] hit_level;
    } probe_t;

    typedef struct packed {
        logic              en;
        logic              wr_id;
        logic [LANE_W-1:0] lane;
        logic [ROW_W-1:0]  row;
        logic [ID_W-1:0]   id;
        logic [LVL_W-1:0]  level;
    } wr_t;

endpackage

FILE: hdl/ohr_cell.sv
// One lookup cell: a bank of ids and levels, compares the passing probe against its row.
module ohr_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [ohr_pkg::LANE_W-1:0]  lane_id,
    input  logic [ohr_pkg::CNT_W-1:0]   fill,
    input  ohr_pkg::wr_t                wr,
    input  ohr_pkg::probe_t             probe_in,
    output ohr_pkg::probe_t             probe_out
);

    logic [ohr_pkg::ID_W-1:0]  id_mem  [ohr_pkg::ROWS];
    logic [ohr_pkg::LVL_W-1:0] lvl_mem [ohr_pkg::ROWS];

    logic [ohr_pkg::ID_W-1:0]  id_rd_reg;
    logic [ohr_pkg::LVL_W-1:0] lvl_rd_reg;
    ohr_pkg::probe_t           probe_reg;
    logic                      valid_reg;

    logic [ohr_pkg::ROW_W+ohr_pkg::LANE_W-1:0] entry_idx;
    logic                                      in_use;
    logic                                      match;

    always_ff @(posedge aclk) begin
        if (wr.en && (wr.lane == lane_id)) begin
            if (wr.wr_id) begin
                id_mem[wr.row] <= wr.id;
            end
            lvl_mem[wr.row] <= wr.level;
        end
        id_rd_reg  <= id_mem[probe_in.row];
        lvl_rd_reg <= lvl_mem[probe_in.row];
        probe_reg  <= probe_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= probe_in.valid;
        end
    end

    assign entry_idx = {probe_reg.row, lane_id};
    assign in_use    = ohr_pkg::CNT_W'(entry_idx) < fill;
    assign match     = valid_reg && in_use && (id_rd_reg == probe_reg.key);

    always_comb begin
        probe_out       = probe_reg;
        probe_out.valid = valid_reg;
        if (match) begin
            probe_out.found     = 1'b1;
            probe_out.hit_lane  = lane_id;
            probe_out.hit_level = lvl_rd_reg;
        end
    end

endmodule

FILE: hdl/ohr_div.sv
// Restoring divider, one quotient bit per cycle, quotient and remainder.
module ohr_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ohr_pkg::DVD_W-1:0]      dividend,
    input  logic [ohr_pkg::DIVISOR_W-1:0]  divisor,
    output logic                           done,
    output logic [ohr_pkg::DVD_W-1:0]      quotient,
    output logic [ohr_pkg::DIVISOR_W-1:0]  remainder
);

    logic [ohr_pkg::DIVISOR_W-1:0] dvs_reg;
    logic [ohr_pkg::DIVISOR_W-1:0] rem_reg;
    logic [ohr_pkg::DVD_W-1:0]     quo_reg;
    logic [ohr_pkg::DCNT_W-1:0]    cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [ohr_pkg::DIVISOR_W:0]   shifted;
    logic [ohr_pkg::DIVISOR_W:0]   diff;
    logic                          ge;
    logic [ohr_pkg::DIVISOR_W-1:0] rem_next;

    assign shifted  = {rem_reg, quo_reg[ohr_pkg::DVD_W-1]};
    assign ge       = shifted >= {1'b0, dvs_reg};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[ohr_pkg::DIVISOR_W-1:0] : shifted[ohr_pkg::DIVISOR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ohr_pkg::DCNT_W'(ohr_pkg::DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[ohr_pkg::DVD_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/one_hit_ratio_tracker.sv
// Top level of the one-hit ratio tracker: sequencer, cell chain and divider.
//
//  port group | dir | payload (lowest bit first)
//  -----------+-----+------------------------------------------------------------
//  s_*        | in  | tdata: object_id[63:0]
//  m_*        | out | tuser: report_valid; tdata: distinct_count, one_hit_count,
//             |     |        one_hit_ratio, table_full, zero pad
//  cfg_*      | in  | report_interval[15:0], written when cfg_wr_en is high
//
// A request streams R = max(1, ceil(distinct/16)) rows through the 16-cell chain;
// an insert then runs the serial divider for the interval remainder, and a report
// runs it once more for the ratio.
// Reset clears the counters, the fill count and the chain; no memory sweep.
// A result waiting on m_tready holds in the output register; the next request
// is taken and searched meanwhile and stalls only at its own hand-off.
module one_hit_ratio_tracker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [63:0]                    s_tdata,   // object_id
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ohr_pkg::TDATA_W-1:0]    m_tdata,   // distinct_count, one_hit_count,
                                                      // one_hit_ratio, table_full, pad
    output logic                           m_tuser,   // report_valid
    input  logic                           cfg_wr_en,
    input  logic [15:0]                    cfg_wr_data
);

`include "one_hit_ratio_tracker_assert.svh"

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_MOD    = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]                       state_reg, state_next;
    logic [ohr_pkg::CNT_W-1:0]        distinct_reg, distinct_next;
    logic [ohr_pkg::CNT_W-1:0]        once_reg, once_next;
    logic                             full_reg, full_next;
    logic [ohr_pkg::INTERVAL_W-1:0]   interval_reg, interval_next;
    logic                             hit_reg, hit_next;
    logic                             m_valid_reg, m_valid_next;

    logic [ohr_pkg::ID_W-1:0]         key_reg;
    logic [ohr_pkg::ROW_W-1:0]        row_reg;
    logic [ohr_pkg::ROW_W-1:0]        last_row_reg;
    logic [ohr_pkg::LANE_W-1:0]       hit_lane_reg;
    logic [ohr_pkg::ROW_W-1:0]        hit_row_reg;
    logic [ohr_pkg::LVL_W-1:0]        hit_level_reg;
    logic                             report_reg;
    logic [ohr_pkg::RATIO_W-1:0]      ratio_reg;
    logic [ohr_pkg::OUT_W-1:0]        m_data_reg;
    logic                             m_user_reg;

    logic [ohr_pkg::CNT_W-1:0]        dist_m1;
    logic [ohr_pkg::CNT_W-1:0]        dist_inc;
    logic                             s_accept;
    logic                             out_free;

    ohr_pkg::probe_t                  chain [ohr_pkg::NUM_CELLS+1];
    ohr_pkg::probe_t                  chain_tail;
    ohr_pkg::wr_t                     wr;

    logic                             div_start;
    logic [ohr_pkg::DVD_W-1:0]        div_dividend;
    logic [ohr_pkg::DIVISOR_W-1:0]    div_divisor;
    logic                             div_done;
    logic [ohr_pkg::DVD_W-1:0]        div_quotient;
    logic [ohr_pkg::DIVISOR_W-1:0]    div_remainder;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign dist_m1  = distinct_reg - ohr_pkg::CNT_W'(1);
    assign dist_inc = distinct_reg + ohr_pkg::CNT_W'(1);

    always_comb begin
        chain[0]           = '0;
        chain[0].valid     = (state_reg == ST_SCAN);
        chain[0].last      = (row_reg == last_row_reg);
        chain[0].key       = key_reg;
        chain[0].row       = row_reg;
    end

    for (genvar i = 0; i < ohr_pkg::NUM_CELLS; i++) begin : g_cell
        ohr_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .lane_id   (ohr_pkg::LANE_W'(i)),
            .fill      (distinct_reg),
            .wr        (wr),
            .probe_in  (chain[i]),
            .probe_out (chain[i+1])
        );
    end

    assign chain_tail = chain[ohr_pkg::NUM_CELLS];

    always_comb begin
        wr       = '0;
        wr.id    = key_reg;
        if (state_reg == ST_UPDATE) begin
            if (hit_reg) begin
                wr.en    = (hit_level_reg == ohr_pkg::LEVEL_ONCE);
                wr.lane  = hit_lane_reg;
                wr.row   = hit_row_reg;
                wr.level = ohr_pkg::LEVEL_MAX;
            end else begin
                wr.en    = (distinct_reg != ohr_pkg::CAP_CNT);
                wr.wr_id = 1'b1;
                wr.lane  = distinct_reg[ohr_pkg::LANE_W-1:0];
                wr.row   = distinct_reg[ohr_pkg::LANE_W +: ohr_pkg::ROW_W];
                wr.level = ohr_pkg::LEVEL_ONCE;
            end
        end
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = ohr_pkg::DVD_W'(distinct_reg);
        div_divisor  = interval_reg;
        unique case (state_reg)
            ST_UPDATE: begin
                div_start    = !hit_reg && (distinct_reg != ohr_pkg::CAP_CNT)
                               && (interval_reg != '0);
                div_dividend = ohr_pkg::DVD_W'(dist_inc);
            end
            ST_MOD: begin
                div_start    = div_done && (div_remainder == '0);
                div_dividend = {once_reg, {ohr_pkg::Q_SHIFT{1'b0}}};
                div_divisor  = ohr_pkg::DIVISOR_W'(distinct_reg);
            end
            default: begin
            end
        endcase
    end

    ohr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    always_comb begin
        state_next    = state_reg;
        distinct_next = distinct_reg;
        once_next     = once_reg;
        full_next     = full_reg;
        interval_next = cfg_wr_en ? cfg_wr_data : interval_reg;
        hit_next      = hit_reg;
        m_valid_next  = m_valid_reg && !m_tready;

        if (chain_tail.valid && chain_tail.found) begin
            hit_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    hit_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (row_reg == last_row_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (chain_tail.valid && chain_tail.last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_OUT;
                if (hit_reg) begin
                    if (hit_level_reg == ohr_pkg::LEVEL_ONCE && once_reg != '0) begin
                        once_next = once_reg - ohr_pkg::CNT_W'(1);
                    end
                end else if (distinct_reg == ohr_pkg::CAP_CNT) begin
                    full_next = 1'b1;
                end else begin
                    distinct_next = dist_inc;
                    once_next     = once_reg + ohr_pkg::CNT_W'(1);
                    if (interval_reg != '0) begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (div_done) begin
                    state_next = (div_remainder == '0) ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            distinct_reg <= '0;
            once_reg     <= '0;
            full_reg     <= 1'b0;
            interval_reg <= ohr_pkg::INTERVAL_RESET;
            hit_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            distinct_reg <= distinct_next;
            once_reg     <= once_next;
            full_reg     <= full_next;
            interval_reg <= interval_next;
            hit_reg      <= hit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_reg      <= s_tdata;
            row_reg      <= '0;
            last_row_reg <= (distinct_reg == '0) ? '0 :
                            dist_m1[ohr_pkg::LANE_W +: ohr_pkg::ROW_W];
            report_reg   <= 1'b0;
            ratio_reg    <= '0;
        end else if (state_reg == ST_SCAN) begin
            row_reg <= row_reg + 1'b1;
        end
        if (chain_tail.valid && chain_tail.found) begin
            hit_lane_reg  <= chain_tail.hit_lane;
            hit_row_reg   <= chain_tail.row;
            hit_level_reg <= chain_tail.hit_level;
        end
        if (state_reg == ST_DIV && div_done) begin
            report_reg <= 1'b1;
            ratio_reg  <= div_quotient[ohr_pkg::RATIO_W-1:0];
        end
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg <= {full_reg, ratio_reg, once_reg, distinct_reg};
            m_user_reg <= report_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = ohr_pkg::TDATA_W'(m_data_reg);
    assign m_tuser  = m_user_reg;

    `OHR_CHECK(a_once_le_distinct, once_reg <= distinct_reg)
    `OHR_CHECK(a_distinct_le_cap, distinct_reg <= ohr_pkg::CAP_CNT)
    `OHR_CHECK_NEXT(a_full_sticky, full_reg, full_reg)
    `OHR_CHECK(a_idle_chain_empty, (state_reg != ST_IDLE) || !chain_tail.valid)

endmodule
